// ----- rtl/rxs_pkg.sv -----
// shared types and constants for the record exchange sorter
// no dependencies
package rxs_pkg;

  localparam int unsigned DefMaxRecords = 64;
  localparam int unsigned IdW           = 16;
  localparam int unsigned KeyW          = 16;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } record_t;

  typedef enum logic [2:0] {
    StIdle,
    StRdI,
    StGetI,
    StScan,
    StWb,
    StEmit
  } state_e;

endpackage

// ----- rtl/record_exchange_sorter.sv -----
// top level of the record exchange sorter: buffer memory plus sequencer
// depends on rxs_pkg, rxs_mem, rxs_ctrl
//
// usage:
//   input words (doc_id_i, sort_key_i, last_i) are taken on a clock edge with
//   start_i high and busy_o low. a word without last_i is written to the buffer
//   on that edge and busy_o stays low. words past MAX_RECORDS are dropped.
//   a word with last_i closes the set of n records: busy_o rises, the buffer is
//   sorted ascending by key with an exchange sort (not stable: equal keys may
//   leave in another order than they came in), then the n records are
//   read out in order, one per cycle, each on out_doc_id_o/out_key_o for one
//   cycle with out_valid_o high; out_last_o marks the final one.
//   sort: for each i in 0..n-2 the sequencer reads position i, scans positions
//   i+1..n-1 swapping in any smaller key, and writes position i back, with one
//   buffer read and at most one write per cycle; the emission follows.
//   busy_o falls in the cycle the last record is shown, so a new set may start.
//   the receiver cannot stall: every strobed word must be taken.
//   reset empties the buffer count; buffer contents are not cleared.
module record_exchange_sorter import rxs_pkg::*; #(
  parameter int unsigned MAX_RECORDS = DefMaxRecords,
  localparam int unsigned AW         = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [IdW-1:0]  doc_id_i,
  input  logic [KeyW-1:0] sort_key_i,
  input  logic            last_i,
  output logic            out_valid_o,
  output logic [IdW-1:0]  out_doc_id_o,
  output logic [KeyW-1:0] out_key_o,
  output logic            out_last_o
);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  record_t       mem_wdata;
  record_t       mem_rdata;

  rxs_mem #(
    .Depth (MAX_RECORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rxs_ctrl #(
    .MaxRecords (MAX_RECORDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .doc_id_i    (doc_id_i),
    .sort_key_i  (sort_key_i),
    .last_i      (last_i),
    .busy_o      (busy_o),
    .out_valid_o (out_valid_o),
    .out_last_o  (out_last_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // emitted words come straight from the buffer's read register
  assign out_doc_id_o = mem_rdata.id;
  assign out_key_o    = mem_rdata.key;

endmodule

// ----- rtl/rxs_mem.sv -----
// record buffer: one write port, one read port, registered read data
// depends on rxs_pkg
module rxs_mem import rxs_pkg::*; #(
  parameter int unsigned Depth = DefMaxRecords,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  record_t       wdata_i,
  input  logic [AW-1:0] raddr_i,
  output record_t       rdata_o
);

  record_t mem_q [Depth];
  record_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rxs_ctrl.sv -----
// sequencer: loads records, runs the exchange sort through the buffer, emits the run
// depends on rxs_pkg; drives the ports of rxs_mem
module rxs_ctrl import rxs_pkg::*; #(
  parameter int unsigned MaxRecords = DefMaxRecords,
  localparam int unsigned AW        = (MaxRecords > 1) ? $clog2(MaxRecords) : 1,
  localparam int unsigned CW        = $clog2(MaxRecords + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [IdW-1:0]  doc_id_i,
  input  logic [KeyW-1:0] sort_key_i,
  input  logic            last_i,
  output logic            busy_o,
  output logic            out_valid_o,
  output logic            out_last_o,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output record_t         mem_wdata_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  record_t         mem_rdata_i
);

  localparam logic [CW-1:0] MaxCnt = CW'(MaxRecords);

  state_e        state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] i_q, i_d;
  logic [AW-1:0] j_q, j_d;
  logic [AW-1:0] jd_q, jd_d;
  logic [AW-1:0] k_q, k_d;
  record_t       cur_q, cur_d;
  logic          ovalid_q, ovalid_d;
  logic          olast_q, olast_d;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] n_last;

  assign fill_inc = (fill_q < MaxCnt) ? fill_q + CW'(1) : fill_q;
  assign n_last   = fill_q - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      i_q      <= '0;
      j_q      <= '0;
      jd_q     <= '0;
      k_q      <= '0;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      i_q      <= i_d;
      j_q      <= j_d;
      jd_q     <= jd_d;
      k_q      <= k_d;
      ovalid_q <= ovalid_d;
      olast_q  <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    i_d         = i_q;
    j_d         = j_q;
    jd_d        = jd_q;
    k_d         = k_q;
    cur_d       = cur_q;
    ovalid_d    = 1'b0;
    olast_d     = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q[AW-1:0];
    mem_wdata_o = '{id: doc_id_i, key: sort_key_i};
    mem_raddr_o = i_q;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          // a full buffer drops the word but still counts as the run's end
          mem_we_o = (fill_q < MaxCnt);
          fill_d   = fill_inc;
          if (last_i) begin
            i_d = '0;
            k_d = '0;
            state_d = (fill_inc == CW'(1)) ? StEmit : StRdI;
          end
        end
      end
      StRdI: begin
        mem_raddr_o = i_q;
        j_d         = i_q + AW'(1);
        state_d     = StGetI;
      end
      StGetI: begin
        cur_d       = mem_rdata_i;
        mem_raddr_o = j_q;
        jd_d        = j_q;
        j_d         = j_q + AW'(1);
        state_d     = StScan;
      end
      StScan: begin
        // cur holds what position i currently owns; a swap parks it at jd
        if (cur_q.key > mem_rdata_i.key) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = jd_q;
          mem_wdata_o = cur_q;
          cur_d       = mem_rdata_i;
        end
        if (CW'(jd_q) == n_last) begin
          state_d = StWb;
        end else begin
          mem_raddr_o = j_q;
          jd_d        = j_q;
          j_d         = j_q + AW'(1);
        end
      end
      StWb: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = i_q;
        mem_wdata_o = cur_q;
        if (CW'(i_q) + CW'(2) == fill_q) begin
          k_d     = '0;
          state_d = StEmit;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = StRdI;
        end
      end
      StEmit: begin
        mem_raddr_o = k_q;
        ovalid_d    = 1'b1;
        if (CW'(k_q) == n_last) begin
          olast_d = 1'b1;
          fill_d  = '0;
          state_d = StIdle;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = ovalid_q;
  assign out_last_o  = olast_q;

endmodule
